### src/pfq_pkg.sv
// Shared types and constants for the prefetch request queue.
// Holds field widths, mode and status codes, register indexes and the cell control struct.
// No dependencies.
`default_nettype none

package pfq_pkg;

    localparam int ADDR_W        = 64;
    localparam int TIME_W        = 48;
    localparam int DELAY_W       = 16;
    localparam int STATUS_W      = 4;
    localparam int COUNT_W       = 5;
    localparam int MODE_W        = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 5;
    localparam int BSL_W         = 4;
    localparam int DEFAULT_DEPTH = 16;

    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 5'd16;
    localparam logic [BSL_W-1:0]   BSL_RESET      = 4'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUASH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_PUSH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_ONLY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 3'd4;

    typedef enum logic [MODE_W-1:0] {
        MODE_MISS  = 2'd0,
        MODE_CAND  = 2'd1,
        MODE_ISSUE = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_IGNORED   = 4'd0,
        STAT_QUEUED    = 4'd1,
        STAT_CACHE_HIT = 4'd2,
        STAT_MQ_HIT    = 4'd3,
        STAT_DUPLICATE = 4'd4,
        STAT_EVICTING  = 4'd5,
        STAT_ISSUED    = 4'd6,
        STAT_DROPPED   = 4'd7,
        STAT_EMPTY     = 4'd8,
        STAT_MISS_DONE = 4'd9
    } status_t;

    // Broadcast from the queue control to every cell.
    typedef struct packed {
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] blk;
        logic [TIME_W-1:0] treq;
        logic [TIME_W-1:0] ins_time;
        logic              remove_match;
        logic              pop_all;
    } pfq_bcast_t;

endpackage

`default_nettype wire

### src/pfq_cell.sv
// One queue slot of the collapsing prefetch queue.
// Holds a block address and issue tick, compares against the broadcast, shifts from its right neighbor.
// Depends on pfq_pkg.
`default_nettype none

module pfq_cell
    import pfq_pkg::*;
(
    input  wire logic              aclk,
    input  wire pfq_bcast_t        bc,
    input  wire logic              valid,
    input  wire logic              load_en,
    input  wire logic              kill_in,
    input  wire logic              sq_in,
    input  wire logic [ADDR_W-1:0] nxt_addr,
    input  wire logic [TIME_W-1:0] nxt_time,
    output logic                   kill_out,
    output logic                   sq_out,
    output logic                   squash,
    output logic [ADDR_W-1:0]      slot_addr,
    output logic [TIME_W-1:0]      slot_time
);

    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic              match;
    logic              shift;

    // The first matching cell starts the collapse; all cells to its right follow.
    assign match    = valid && ((addr_reg & bc.mask) == bc.blk);
    assign kill_out = kill_in | match;
    assign shift    = bc.pop_all | (bc.remove_match & kill_out);

    // Tail squash runs from the right: a cell squashes only if everything after it did.
    assign squash = valid && (time_reg >= bc.treq) && sq_in;
    assign sq_out = !valid || squash;

    always_comb begin
        addr_next = addr_reg;
        time_next = time_reg;
        if (load_en) begin
            addr_next = bc.blk;
            time_next = bc.ins_time;
        end else if (shift) begin
            addr_next = nxt_addr;
            time_next = nxt_time;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        time_reg <= time_next;
    end

    assign slot_addr = addr_reg;
    assign slot_time = time_reg;

endmodule

`default_nettype wire

### src/prefetch_request_queue_unit.sv
// Top level of the prefetch request queue: control, configuration and the row of cells.
// Depends on pfq_pkg and pfq_cell.
//
// Usage: requests enter on the s_ channel (tuser carries the mode, tdata the address,
// miss tick, delay and cache flags) and one result leaves on the m_ channel for every
// request. A demand miss removes a queued entry of its block; a prefetch candidate is
// filtered and appended; an issue request pops the head entry.
// The queue is a row of QUEUE_DEPTH cells, oldest at cell 0. Every cell compares its
// block against the broadcast address in parallel, and a removal collapses the row by
// having each cell from the match onward take its right neighbor's contents at once.
// Latency: most requests finish at the accepting edge, so the result is visible one
// cycle later and a new request may be taken in that same cycle. A miss with tail
// squashing first passes through the squash state. A candidate that meets a full queue
// pops head entries in the evict state until it is below the capacity, then inserts,
// so the cost grows when the capacity was lowered below the current occupancy.
// The result sits in an output register; a new request is taken only while that
// register is empty or being emptied, so a stalled receiver holds off the sender.
// Synchronous reset empties the queue and restores the register defaults. Configuration
// writes are taken in any cycle and must only happen while the queue is idle.
`default_nettype none

module prefetch_request_queue_unit
    import pfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Request channel.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // tdata from bit 0: address[63:0], time_req[47:0], delay[15:0], uncacheable,
    // inst_read, in_cache, in_miss_queue, zero fill.
    input  wire logic [135:0]          s_tdata,
    // tuser: mode[1:0].
    input  wire logic [MODE_W-1:0]     s_tuser,
    // Result channel.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // tdata from bit 0: out_address[63:0], out_time[47:0], matched_removed,
    // squashed_count[4:0], entry_count[4:0], bus_request, zero fill.
    output logic [127:0]               m_tdata,
    // tuser: status[3:0].
    output logic [STATUS_W-1:0]        m_tuser,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUASH,
        ST_EVICT
    } state_t;

    // Request fields.
    logic [ADDR_W-1:0]  in_addr;
    logic [TIME_W-1:0]  in_treq;
    logic [DELAY_W-1:0] in_delay;
    logic               in_uncach, in_iread, in_incache, in_inmq;
    mode_t              in_mode;

    assign in_addr    = s_tdata[63:0];
    assign in_treq    = s_tdata[111:64];
    assign in_delay   = s_tdata[127:112];
    assign in_uncach  = s_tdata[128];
    assign in_iread   = s_tdata[129];
    assign in_incache = s_tdata[130];
    assign in_inmq    = s_tdata[131];
    assign in_mode    = mode_t'(s_tuser);

    // Control and configuration registers.
    state_t             state_reg, state_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [ADDR_W-1:0]  blk_reg, blk_next;
    logic [TIME_W-1:0]  tslot_reg, tslot_next;
    logic [TIME_W-1:0]  treq_reg, treq_next;
    logic               matched_reg, matched_next;
    logic [COUNT_W-1:0] cap_cfg_reg;
    logic               squash_cfg_reg, check_push_reg, data_only_reg;
    logic [BSL_W-1:0]   bsl_reg;

    // Output register.
    logic               m_tvalid_reg, m_tvalid_next;
    status_t            o_status_reg, o_status_next;
    logic [ADDR_W-1:0]  o_addr_reg, o_addr_next;
    logic [TIME_W-1:0]  o_time_reg, o_time_next;
    logic               o_matched_reg, o_matched_next;
    logic [COUNT_W-1:0] o_squashed_reg, o_squashed_next;
    logic [COUNT_W-1:0] o_count_reg, o_count_next;
    logic               o_busreq_reg, o_busreq_next;

    logic               s_fire;
    logic               out_load;
    logic               insert;
    logic [ADDR_W-1:0]  blk_mask;
    logic [ADDR_W-1:0]  in_blk;
    logic [TIME_W:0]    t_sum;
    logic [TIME_W-1:0]  t_sat;
    logic [OCC_W-1:0]   cap_eff;
    logic [OCC_W-1:0]   occ_sq;
    logic               any_sq;
    pfq_bcast_t         bc;

    // Cell row wiring.
    logic [QUEUE_DEPTH:0]   kill_chain;
    logic [QUEUE_DEPTH:0]   sq_chain;
    logic [QUEUE_DEPTH-1:0] squash_vec;
    logic [QUEUE_DEPTH-1:0] first_sq;
    logic [QUEUE_DEPTH-1:0] load_vec;
    logic [ADDR_W-1:0]      cell_addr [QUEUE_DEPTH];
    logic [TIME_W-1:0]      cell_time [QUEUE_DEPTH];
    logic [ADDR_W-1:0]      nxt_addr  [QUEUE_DEPTH];
    logic [TIME_W-1:0]      nxt_time  [QUEUE_DEPTH];

    assign s_tready  = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign blk_mask = ~((ADDR_W'(1) << bsl_reg) - ADDR_W'(1));
    assign in_blk   = in_addr & blk_mask;

    // Candidate issue tick saturates at the top of the tick range.
    assign t_sum = {1'b0, in_treq} + (TIME_W + 1)'(in_delay);
    assign t_sat = t_sum[TIME_W] ? {TIME_W{1'b1}} : t_sum[TIME_W-1:0];

    // A capacity of zero behaves as one, anything above the depth as the depth.
    always_comb begin
        if (cap_cfg_reg == '0) begin
            cap_eff = OCC_W'(1);
        end else if (32'(cap_cfg_reg) > 32'(QUEUE_DEPTH)) begin
            cap_eff = OCC_W'(QUEUE_DEPTH);
        end else begin
            cap_eff = OCC_W'(cap_cfg_reg);
        end
    end

    assign kill_chain[0]           = 1'b0;
    assign sq_chain[QUEUE_DEPTH]   = 1'b1;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign nxt_addr[i] = cell_addr[i];
            assign nxt_time[i] = cell_time[i];
        end else begin : g_mid
            assign nxt_addr[i] = cell_addr[i+1];
            assign nxt_time[i] = cell_time[i+1];
        end

        if (i == 0) begin : g_head
            assign first_sq[i] = squash_vec[i];
        end else begin : g_rest
            assign first_sq[i] = squash_vec[i] && !squash_vec[i-1];
        end

        assign load_vec[i] = insert && (occ_reg == OCC_W'(i));

        pfq_cell u_cell (
            .aclk      (aclk),
            .bc        (bc),
            .valid     (occ_reg > OCC_W'(i)),
            .load_en   (load_vec[i]),
            .kill_in   (kill_chain[i]),
            .sq_in     (sq_chain[i+1]),
            .nxt_addr  (nxt_addr[i]),
            .nxt_time  (nxt_time[i]),
            .kill_out  (kill_chain[i+1]),
            .sq_out    (sq_chain[i]),
            .squash    (squash_vec[i]),
            .slot_addr (cell_addr[i]),
            .slot_time (cell_time[i])
        );
    end

    // The squashed cells form a run at the tail; its first cell is the new occupancy.
    always_comb begin
        occ_sq = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (first_sq[i]) begin
                occ_sq = occ_sq | OCC_W'(i);
            end
        end
    end
    assign any_sq = |squash_vec;

    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        blk_next     = blk_reg;
        tslot_next   = tslot_reg;
        treq_next    = treq_reg;
        matched_next = matched_reg;

        bc.mask         = blk_mask;
        bc.blk          = (state_reg == ST_IDLE) ? in_blk : blk_reg;
        bc.treq         = treq_reg;
        bc.ins_time     = (state_reg == ST_IDLE) ? t_sat : tslot_reg;
        bc.remove_match = 1'b0;
        bc.pop_all      = 1'b0;
        insert          = 1'b0;

        out_load        = 1'b0;
        o_status_next   = STAT_IGNORED;
        o_addr_next     = '0;
        o_time_next     = '0;
        o_matched_next  = 1'b0;
        o_squashed_next = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (in_mode)
                        MODE_MISS: begin
                            if (in_uncach || (in_iread && data_only_reg)) begin
                                out_load = 1'b1;
                            end else begin
                                bc.remove_match = 1'b1;
                                matched_next    = kill_chain[QUEUE_DEPTH];
                                if (kill_chain[QUEUE_DEPTH]) begin
                                    occ_next = occ_reg - OCC_W'(1);
                                end
                                if (squash_cfg_reg) begin
                                    treq_next  = in_treq;
                                    state_next = ST_SQUASH;
                                end else begin
                                    out_load       = 1'b1;
                                    o_status_next  = STAT_MISS_DONE;
                                    o_matched_next = kill_chain[QUEUE_DEPTH];
                                end
                            end
                        end
                        MODE_CAND: begin
                            o_time_next = t_sat;
                            if (check_push_reg && in_incache) begin
                                out_load      = 1'b1;
                                o_status_next = STAT_CACHE_HIT;
                            end else if (in_inmq) begin
                                out_load      = 1'b1;
                                o_status_next = STAT_MQ_HIT;
                            end else if (kill_chain[QUEUE_DEPTH]) begin
                                out_load      = 1'b1;
                                o_status_next = STAT_DUPLICATE;
                            end else if (occ_reg >= cap_eff) begin
                                blk_next   = in_blk;
                                tslot_next = t_sat;
                                state_next = ST_EVICT;
                            end else begin
                                insert        = 1'b1;
                                occ_next      = occ_reg + OCC_W'(1);
                                out_load      = 1'b1;
                                o_status_next = STAT_QUEUED;
                            end
                        end
                        MODE_ISSUE: begin
                            out_load = 1'b1;
                            if (occ_reg == '0) begin
                                o_status_next = STAT_EMPTY;
                            end else begin
                                bc.pop_all    = 1'b1;
                                occ_next      = occ_reg - OCC_W'(1);
                                o_addr_next   = cell_addr[0];
                                o_time_next   = cell_time[0];
                                o_status_next = (!check_push_reg && in_incache) ?
                                                STAT_DROPPED : STAT_ISSUED;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SQUASH: begin
                if (any_sq) begin
                    occ_next = occ_sq;
                end
                out_load        = 1'b1;
                o_status_next   = STAT_MISS_DONE;
                o_matched_next  = matched_reg;
                o_squashed_next = COUNT_W'(occ_reg - occ_next);
                state_next      = ST_IDLE;
            end
            ST_EVICT: begin
                if (occ_reg >= cap_eff) begin
                    bc.pop_all = 1'b1;
                    occ_next   = occ_reg - OCC_W'(1);
                end else begin
                    insert        = 1'b1;
                    occ_next      = occ_reg + OCC_W'(1);
                    out_load      = 1'b1;
                    o_status_next = STAT_EVICTING;
                    o_time_next   = tslot_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        o_count_next  = COUNT_W'(occ_next);
        o_busreq_next = (occ_next != '0);
        m_tvalid_next = out_load || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            occ_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            matched_reg    <= 1'b0;
            treq_reg       <= '0;
            cap_cfg_reg    <= CAPACITY_RESET;
            squash_cfg_reg <= 1'b0;
            check_push_reg <= 1'b0;
            data_only_reg  <= 1'b0;
            bsl_reg        <= BSL_RESET;
        end else begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            m_tvalid_reg <= m_tvalid_next;
            matched_reg  <= matched_next;
            blk_reg      <= blk_next;
            tslot_reg    <= tslot_next;
            treq_reg     <= treq_next;
            if (out_load) begin
                o_status_reg   <= o_status_next;
                o_addr_reg     <= o_addr_next;
                o_time_reg     <= o_time_next;
                o_matched_reg  <= o_matched_next;
                o_squashed_reg <= o_squashed_next;
                o_count_reg    <= o_count_next;
                o_busreq_reg   <= o_busreq_next;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CAPACITY:   cap_cfg_reg    <= cfg_data;
                    CFG_SQUASH:     squash_cfg_reg <= cfg_data[0];
                    CFG_CHECK_PUSH: check_push_reg <= cfg_data[0];
                    CFG_DATA_ONLY:  data_only_reg  <= cfg_data[0];
                    CFG_BLOCK_LOG2: bsl_reg        <= cfg_data[BSL_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = o_status_reg;
    assign m_tdata  = {4'b0, o_busreq_reg, o_count_reg, o_squashed_reg, o_matched_reg,
                       o_time_reg, o_addr_reg};

    // The queue never holds more entries than it has cells.
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(occ_reg) <= QUEUE_DEPTH)
        else $error("occupancy exceeds queue depth");

    // Squashed cells form a single run at the tail.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(first_sq))
        else $error("squash run is not contiguous");

    // While a squash or an eviction is in progress the output register is empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !m_tvalid_reg)
        else $error("result pending during a multi-cycle request");

    // An issue on a nonempty queue removes exactly one entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (in_mode == MODE_ISSUE) && (occ_reg != '0)) |=>
        (occ_reg == $past(occ_reg) - OCC_W'(1)))
        else $error("issue did not pop exactly one entry");

    // At most one cell takes the new entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(load_vec))
        else $error("more than one cell loaded");

endmodule

`default_nettype wire
